@@ src/md5_stream_hasher_defines.svh @@
// Assertion macros shared by the MD5 stream hasher checker.
// No dependencies.
`ifndef MD5_STREAM_HASHER_DEFINES_SVH
`define MD5_STREAM_HASHER_DEFINES_SVH

// Assert that prop holds at every clock edge out of reset.
`define MD5_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assert that prop holds at every clock edge, reset included.
`define MD5_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/md5_pkg.sv @@
// Package for the MD5 stream hasher: constants, round tables and helper types.
// No dependencies.
package md5_pkg;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;

    localparam logic [31:0] IvA = 32'h67452301;
    localparam logic [31:0] IvB = 32'hefcdab89;
    localparam logic [31:0] IvC = 32'h98badcfe;
    localparam logic [31:0] IvD = 32'h10325476;

    localparam logic [7:0] PadByte = 8'h80;

    // Queue entry from the front end: one byte for the buffer, or an end mark.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } md5_item_t;

    function automatic logic [31:0] sine_k(input logic [5:0] i);
        logic [31:0] t;
        case (i)
            6'd0:  t = 32'hd76aa478; 6'd1:  t = 32'he8c7b756;
            6'd2:  t = 32'h242070db; 6'd3:  t = 32'hc1bdceee;
            6'd4:  t = 32'hf57c0faf; 6'd5:  t = 32'h4787c62a;
            6'd6:  t = 32'ha8304613; 6'd7:  t = 32'hfd469501;
            6'd8:  t = 32'h698098d8; 6'd9:  t = 32'h8b44f7af;
            6'd10: t = 32'hffff5bb1; 6'd11: t = 32'h895cd7be;
            6'd12: t = 32'h6b901122; 6'd13: t = 32'hfd987193;
            6'd14: t = 32'ha679438e; 6'd15: t = 32'h49b40821;
            6'd16: t = 32'hf61e2562; 6'd17: t = 32'hc040b340;
            6'd18: t = 32'h265e5a51; 6'd19: t = 32'he9b6c7aa;
            6'd20: t = 32'hd62f105d; 6'd21: t = 32'h02441453;
            6'd22: t = 32'hd8a1e681; 6'd23: t = 32'he7d3fbc8;
            6'd24: t = 32'h21e1cde6; 6'd25: t = 32'hc33707d6;
            6'd26: t = 32'hf4d50d87; 6'd27: t = 32'h455a14ed;
            6'd28: t = 32'ha9e3e905; 6'd29: t = 32'hfcefa3f8;
            6'd30: t = 32'h676f02d9; 6'd31: t = 32'h8d2a4c8a;
            6'd32: t = 32'hfffa3942; 6'd33: t = 32'h8771f681;
            6'd34: t = 32'h6d9d6122; 6'd35: t = 32'hfde5380c;
            6'd36: t = 32'ha4beea44; 6'd37: t = 32'h4bdecfa9;
            6'd38: t = 32'hf6bb4b60; 6'd39: t = 32'hbebfbc70;
            6'd40: t = 32'h289b7ec6; 6'd41: t = 32'heaa127fa;
            6'd42: t = 32'hd4ef3085; 6'd43: t = 32'h04881d05;
            6'd44: t = 32'hd9d4d039; 6'd45: t = 32'he6db99e5;
            6'd46: t = 32'h1fa27cf8; 6'd47: t = 32'hc4ac5665;
            6'd48: t = 32'hf4292244; 6'd49: t = 32'h432aff97;
            6'd50: t = 32'hab9423a7; 6'd51: t = 32'hfc93a039;
            6'd52: t = 32'h655b59c3; 6'd53: t = 32'h8f0ccc92;
            6'd54: t = 32'hffeff47d; 6'd55: t = 32'h85845dd1;
            6'd56: t = 32'h6fa87e4f; 6'd57: t = 32'hfe2ce6e0;
            6'd58: t = 32'ha3014314; 6'd59: t = 32'h4e0811a1;
            6'd60: t = 32'hf7537e82; 6'd61: t = 32'hbd3af235;
            6'd62: t = 32'h2ad7d2bb; 6'd63: t = 32'heb86d391;
            default: t = 32'h0;
        endcase
        return t;
    endfunction

    function automatic logic [4:0] rot_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'b0000: s = 5'd7;  4'b0001: s = 5'd12; 4'b0010: s = 5'd17; 4'b0011: s = 5'd22;
            4'b0100: s = 5'd5;  4'b0101: s = 5'd9;  4'b0110: s = 5'd14; 4'b0111: s = 5'd20;
            4'b1000: s = 5'd4;  4'b1001: s = 5'd11; 4'b1010: s = 5'd16; 4'b1011: s = 5'd23;
            4'b1100: s = 5'd6;  4'b1101: s = 5'd10; 4'b1110: s = 5'd15; 4'b1111: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] msg_idx(input logic [5:0] i);
        logic [3:0] k;
        logic [7:0] p;
        case (i[5:4])
            2'd0: p = {2'b00, i};
            2'd1: p = 8'(5 * i + 1);
            2'd2: p = 8'(3 * i + 5);
            2'd3: p = 8'(7 * i);
            default: p = 8'd0;
        endcase
        k = p[3:0];
        return k;
    endfunction

endpackage

@@ src/md5_front.sv @@
// MD5 front end: accepts input beats, drops empty non-last beats, and
// feeds a short queue towards the block engine. Depends on md5_pkg.
module md5_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  md5_pkg::md5_item_t in_item,
    output logic              q_valid,
    input  logic              q_ready,
    output md5_pkg::md5_item_t q_item
);

    md5_pkg::md5_item_t mem_reg [md5_pkg::QueueDepth];
    logic [md5_pkg::QueuePtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [md5_pkg::QueuePtrW:0]   count_reg, count_next;
    logic push, pop;

    assign in_ready = (count_reg != 3'(md5_pkg::QueueDepth));
    // Drop beats that carry neither a byte nor an end mark.
    assign push     = in_valid && in_ready && (in_item.has_byte || in_item.last);
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (!push && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

@@ src/md5_engine.sv @@
// MD5 block engine: block buffer, padding sequencer and one round per cycle.
// Depends on md5_pkg.
module md5_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  md5_pkg::md5_item_t q_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [127:0]       out_digest
);

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_ROUND = 6'b000010,
        ST_ADD   = 6'b000100,
        ST_PAD   = 6'b001000,
        ST_LEN   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] buf_reg [16];
    logic [31:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic [31:0] ra_reg, rb_reg, rc_reg, rd_reg;
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  rnd_reg;
    logic        fin_reg;   // message end seen, padding in progress
    logic [127:0] dig_reg;
    logic        ovalid_reg;
    // A last item that filled the block keeps its end mark until ST_ADD.
    logic        pend_last_reg;
    // Length bytes written: the next compression is the final one.
    logic        len_done_reg;

    // Byte to write into the buffer this cycle
    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [63:0] bits;

    logic [31:0] f, sum, rot;
    logic [5:0]  r;
    logic [4:0]  s;

    assign bits = len_reg << 3;
    assign r    = rnd_reg;
    assign s    = md5_pkg::rot_s(r);

    always_comb begin
        case (r[5:4])
            2'd0: f = (rb_reg & rc_reg) | (~rb_reg & rd_reg);
            2'd1: f = (rd_reg & rb_reg) | (~rd_reg & rc_reg);
            2'd2: f = rb_reg ^ rc_reg ^ rd_reg;
            2'd3: f = rc_reg ^ (rb_reg | ~rd_reg);
            default: f = '0;
        endcase
        sum = f + ra_reg + md5_pkg::sine_k(r) + buf_reg[md5_pkg::msg_idx(r)];
        rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    end

    assign q_ready    = (state_reg == ST_LOAD);
    assign out_valid  = ovalid_reg;
    assign out_digest = dig_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_byte = q_item.data;
        case (state_reg)
            ST_LOAD: wr_en = q_valid && q_item.has_byte;
            ST_PAD: begin
                wr_en   = 1'b1;
                wr_byte = fin_reg ? 8'h00 : md5_pkg::PadByte;
            end
            ST_LEN: begin
                wr_en   = 1'b1;
                wr_byte = bits[{fill_reg[2:0], 3'b000} +: 8];
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (q_valid) begin
                    if (q_item.has_byte && fill_reg == 6'd63) state_next = ST_ROUND;
                    else if (q_item.last) state_next = ST_PAD;
                end
            end
            ST_ROUND: if (rnd_reg == 6'd63) state_next = ST_ADD;
            ST_ADD: begin
                if (fin_reg && len_done_reg) state_next = ST_OUT;
                else if (fin_reg || pend_last_reg) state_next = ST_PAD;
                else state_next = ST_LOAD;
            end
            ST_PAD: begin
                if (fill_reg == 6'd63) state_next = ST_ROUND;
                else if (fill_reg == 6'd55) state_next = ST_LEN;
            end
            ST_LEN: if (fill_reg == 6'd63) state_next = ST_ROUND;
            // Hold the digest until the beat is taken.
            ST_OUT: if (out_ready) state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            fill_reg      <= '0;
            len_reg       <= '0;
            rnd_reg       <= '0;
            fin_reg       <= 1'b0;
            pend_last_reg <= 1'b0;
            ovalid_reg    <= 1'b0;
            ca_reg <= md5_pkg::IvA; cb_reg <= md5_pkg::IvB;
            cc_reg <= md5_pkg::IvC; cd_reg <= md5_pkg::IvD;
        end else begin
            state_reg <= state_next;
            if (ovalid_reg && out_ready) ovalid_reg <= 1'b0;
            if (wr_en) fill_reg <= fill_reg + 1'b1;
            case (state_reg)
                ST_LOAD: begin
                    if (q_valid) begin
                        if (q_item.has_byte) len_reg <= len_reg + 1'b1;
                        pend_last_reg <= q_item.last;
                    end
                    if (q_valid && q_item.has_byte && fill_reg == 6'd63) begin
                        ra_reg <= ca_reg; rb_reg <= cb_reg;
                        rc_reg <= cc_reg; rd_reg <= cd_reg;
                        rnd_reg <= '0;
                    end
                end
                ST_ROUND: begin
                    ra_reg  <= rd_reg;
                    rd_reg  <= rc_reg;
                    rc_reg  <= rb_reg;
                    rb_reg  <= rb_reg + rot;
                    rnd_reg <= rnd_reg + 1'b1;
                end
                ST_ADD: begin
                    if (fin_reg && len_done_reg) begin
                        dig_reg <= {cd_reg + rd_reg, cc_reg + rc_reg,
                                    cb_reg + rb_reg, ca_reg + ra_reg};
                        ovalid_reg <= 1'b1;
                        ca_reg <= md5_pkg::IvA; cb_reg <= md5_pkg::IvB;
                        cc_reg <= md5_pkg::IvC; cd_reg <= md5_pkg::IvD;
                        len_reg <= '0;
                        fin_reg <= 1'b0;
                    end else begin
                        ca_reg <= ca_reg + ra_reg; cb_reg <= cb_reg + rb_reg;
                        cc_reg <= cc_reg + rc_reg; cd_reg <= cd_reg + rd_reg;
                    end
                end
                ST_PAD: begin
                    fin_reg <= 1'b1;
                end
                default: ;
            endcase
            if ((state_reg == ST_PAD || state_reg == ST_LEN) && fill_reg == 6'd63) begin
                ra_reg <= ca_reg; rb_reg <= cb_reg;
                rc_reg <= cc_reg; rd_reg <= cd_reg;
                rnd_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_done_reg <= 1'b0;
        end else if (state_reg == ST_LEN) begin
            len_done_reg <= 1'b1;
        end else if (state_reg == ST_ADD && len_done_reg) begin
            len_done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) buf_reg[fill_reg[5:2]][{fill_reg[1:0], 3'b000} +: 8] <= wr_byte;
    end

endmodule

@@ src/md5_stream_hasher.sv @@
// MD5 stream hasher top level: front-end queue and block engine.
// Depends on md5_pkg, md5_front and md5_engine.
//
//  channel   dir  tdata                          tuser / tlast
//  s_axis    in   [7:0] data_byte                tuser = has_byte, tlast = last
//  m_axis    out  [63:0] digest_low, [127:64] digest_high
//
// Bytes load one per cycle when the engine is in ST_LOAD; a full block then
// holds the engine for 64 rounds, one per cycle, and the chaining add. A last
// beat adds padding writes, one byte a cycle, plus one or two compressions.
// Reset: synchronous, active low; loads the MD5 initial value at once.
// The queue takes beats until its four entries fill, also during rounds.
module md5_stream_hasher (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] has_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [63:0] digest_low, [127:64] digest_high
);

    md5_pkg::md5_item_t in_item, q_item;
    logic q_valid, q_ready;

    always_comb begin
        in_item.data     = s_tdata;
        in_item.has_byte = s_tuser;
        in_item.last     = s_tlast;
    end

    md5_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    md5_engine u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_digest(m_tdata)
    );

endmodule

@@ src/md5_checker.sv @@
// Port-level checker for the MD5 stream hasher, bound to the top level.
// Depends on md5_stream_hasher_defines.svh.
`include "md5_stream_hasher_defines.svh"
module md5_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);
    `MD5_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "digest beat dropped while stalled")
    `MD5_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_tvalid, "digest valid out of reset")
    `MD5_ASSERT_ALWAYS(a_rdy, aclk, !aresetn |=> s_tready, "input not ready out of reset")
    `MD5_ASSERT(a_one, aclk, aresetn, m_tvalid && m_tready |=> !m_tvalid, "digest beat repeated")
endmodule

bind md5_stream_hasher md5_checker u_md5_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

@@ tb/tb_top.sv @@
// Self-checking bench for md5_stream_hasher: byte beats in, digests out.
// Depends on md5_pkg and md5_stream_hasher; predicts digests with its own MD5.
module tb_top;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;

    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
        logic       typed;
        logic [127:0] digest;
    } stim_row_t;

    logic [31:0] hash_words[4];
    logic [7:0]  blk_bytes[64];
    int          blk_fill;
    logic [63:0] msg_len;
    logic [127:0] digest_q[$];
    int          n_errors;
    int          n_digests;
    int          n_beats;
    stim_row_t   dir_rows[$];

    md5_stream_hasher i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic logic [31:0] rotl(logic [31:0] x, int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    task automatic hash_block();
        logic [31:0] w[16];
        logic [31:0] a, b, c, d, f, t;
        int k, s;
        int shifts[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        logic [31:0] sines[64] = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
            32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
            32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
            32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
            32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
            32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
        a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
        for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
                f = (b & c) | (~b & d); k = i;
            end else if (i < 32) begin
                f = (d & b) | (~d & c); k = (5 * i + 1) % 16;
            end else if (i < 48) begin
                f = b ^ c ^ d; k = (3 * i + 5) % 16;
            end else begin
                f = c ^ (b | ~d); k = (7 * i) % 16;
            end
            s = shifts[(i / 16) * 4 + i % 4];
            t = f + a + sines[i] + w[k];
            a = d; d = c; c = b;
            b = b + rotl(t, s);
        end
        hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
    endtask

    task automatic push_byte(logic [7:0] v);
        blk_bytes[blk_fill] = v;
        blk_fill++;
        if (blk_fill == 64) begin
            hash_block();
            blk_fill = 0;
        end
    endtask

    task automatic restart_digest();
        hash_words = '{md5_pkg::IvA, md5_pkg::IvB, md5_pkg::IvC, md5_pkg::IvD};
        blk_fill = 0;
        msg_len = '0;
    endtask

    // Advance the predictor by one accepted beat; queue a digest on last.
    task automatic predict_beat(logic [7:0] data, logic has_byte, logic last);
        logic [63:0] bits;
        if (has_byte) begin
            msg_len++;
            push_byte(data);
        end
        if (last) begin
            bits = msg_len << 3;
            push_byte(md5_pkg::PadByte);
            while (blk_fill != 56) push_byte(8'h00);
            for (int i = 0; i < 8; i++) push_byte(bits[8*i +: 8]);
            digest_q.push_back({hash_words[3], hash_words[2], hash_words[1], hash_words[0]});
            restart_digest();
        end
    endtask

    task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Drive one beat at the falling edge and hold it until it is taken.
    task automatic send_beat(logic [7:0] data, logic has_byte, logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has_byte;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_beat(data, has_byte, last);
        n_beats++;
        @(negedge aclk);
    endtask

    task automatic idle_gap(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic add_row(logic [7:0] d, logic h, logic l, logic typed, logic [127:0] dg);
        stim_row_t r;
        r.data = d; r.has_byte = h; r.last = l; r.typed = typed; r.digest = dg;
        dir_rows.push_back(r);
    endtask

    // Receiver: stall on its own pattern, check each digest against the queue.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_digests++;
            if (digest_q.size() == 0) report_mismatch("unexpected digest", m_tdata, '0);
            else begin
                logic [127:0] want;
                want = digest_q.pop_front();
                if (m_tdata[63:0] !== want[63:0])
                    report_mismatch("digest_low", 128'(m_tdata[63:0]), 128'(want[63:0]));
                if (m_tdata[127:64] !== want[127:64])
                    report_mismatch("digest_high", 128'(m_tdata[127:64]), 128'(want[127:64]));
            end
        end
    end

    always @(negedge aclk) begin
        int mode;
        mode = (n_beats / 150) % 3;
        if (!aresetn || mode == 0) m_tready <= 1'b1;
        else if (mode == 1) m_tready <= ($urandom_range(0, 3) != 0);
        else m_tready <= ($urandom_range(0, 9) < 3);
    end

    initial begin
        #2000000;
        $display("timeout after %0d beats", n_beats);
        $display("status: fail");
        $finish;
    end

    initial begin
        int burst, mlen, rows_typed;
        int lens[6];
        logic [127:0] row_want;
        n_errors = 0; n_digests = 0; n_beats = 0;
        lens = '{55, 56, 63, 64, 119, 120};
        for (int i = 0; i < 64; i++) blk_bytes[i] = '0;
        restart_digest();
        // Digests of "", "a" and "abc", byte 0 lowest.
        add_row(8'h00, 1'b0, 1'b1, 1'b1, 128'h7e42f8ec_980980e9_04b2008f_d98c1dd4);
        add_row(8'h61, 1'b1, 1'b1, 1'b1, 128'h61267769_e299c331_a8b6f1c0_b975c10c);
        add_row(8'h61, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h62, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h63, 1'b1, 1'b1, 1'b1, 128'h727fe128_7d3f96d6_b04fd23c_98500190);
        add_row(8'hff, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'hff, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'hff, 1'b1, 1'b1, 1'b0, '0);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        rows_typed = 0;
        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].data, dir_rows[i].has_byte, dir_rows[i].last);
            // The predictor must agree with the typed-in constants too.
            if (dir_rows[i].typed) begin
                rows_typed++;
                row_want = dir_rows[i].digest;
                if (digest_q.size() == 0 || digest_q[$] !== row_want)
                    report_mismatch("typed digest", digest_q[$], row_want);
                digest_q[$] = row_want;
            end
        end
        // Messages of lengths around the padding boundaries.
        foreach (lens[j]) begin
            for (int i = 0; i < lens[j]; i++)
                send_beat(8'($urandom), 1'b1, (i == lens[j] - 1) && (j % 2 == 0));
            if (j % 2 == 1) send_beat(8'($urandom), 1'b0, 1'b1);
        end
        // Random messages in bursts; mostly short, some spanning several blocks.
        while (n_beats < 1200) begin
            mlen = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200) : $urandom_range(0, 70);
            burst = $urandom_range(1, 40);
            for (int i = 0; i < mlen; i++) begin
                if ($urandom_range(0, 15) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
                send_beat(8'($urandom), 1'b1, 1'b0);
                burst--;
                if (burst == 0) begin
                    idle_gap($urandom_range(1, 12));
                    burst = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 40);
                end
            end
            if ($urandom_range(0, 1)) send_beat(8'($urandom), 1'b1, 1'b1);
            else send_beat(8'($urandom), 1'b0, 1'b1);
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (digest_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("covered %0d beats and %0d digests, %0d typed-in, with stalls on both sides",
                 n_beats, n_digests, rows_typed);
        if (n_errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
